// ===== hw/rtl/tgi_pkg.sv =====
package tgi_pkg;

    localparam int FLUX_W = 32;
    localparam int FRAC_W = 16;
    localparam int ADDR_W = 15;
    localparam int POS_W  = 32;

    typedef logic [FLUX_W-1:0] t_flux;
    typedef logic [FRAC_W-1:0] t_frac;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [POS_W-1:0]  t_pos;

    typedef enum logic [2:0] {
        REG_X_LOWER = 3'd0,
        REG_Y_LOWER = 3'd1,
        REG_Z_LOWER = 3'd2,
        REG_X_SCALE = 3'd3,
        REG_Y_SCALE = 3'd4,
        REG_Z_SCALE = 3'd5
    } t_cfg_reg;

    localparam int REG_COUNT = 6;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } t_mode;

endpackage

// ===== hw/rtl/tgi_flux_mem.sv =====
module tgi_flux_mem
    import tgi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_addr,
    input  t_flux i_wdata,
    output t_flux o_rdata
);

    t_flux r_mem [0:(2**ADDR_W)-1];
    t_flux r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tgi_lerp.sv =====
module tgi_lerp
    import tgi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_flux i_a,
    input  t_flux i_b,
    input  t_frac i_frac,
    output logic  o_valid,
    output t_flux o_result
);

    logic                     r_s1_vld;
    logic                     r_s2_vld;
    t_flux                    r_a;
    logic signed [FLUX_W:0]   r_diff;
    t_frac                    r_f;
    t_flux                    r_res;
    logic signed [FLUX_W+FRAC_W+1:0] prod;
    logic [FLUX_W+1:0]        sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_comb begin
        prod = r_diff * $signed({1'b0, r_f});
        sum  = {2'b00, r_a} + prod[FLUX_W+FRAC_W+1:FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        r_a    <= i_a;
        r_f    <= i_frac;
        r_diff <= $signed({1'b0, i_b}) - $signed({1'b0, i_a});
        r_res  <= sum[FLUX_W-1:0];
    end

    assign o_valid  = r_s2_vld;
    assign o_result = r_res;

endmodule

// ===== hw/rtl/trilinear_grid_interpolator.sv =====
// For a query the position is mapped to the grid, then eight serial reads of the
// single-port flux memory feed seven passes through the two-stage interpolation unit.
// A position outside the grid skips the reads; one at the upper grid edge returns the
// word at its lower corner. One query in flight, so no new query word is taken until
// its result word is loaded for output; load words one per cycle when idle.
// Synchronous active-low reset clears control and configuration, not the flux memory.
module trilinear_grid_interpolator
    import tgi_pkg::*;
#(
    parameter int ENERGY_BINS = 8,
    parameter int POINTS_X    = 16,
    parameter int POINTS_Y    = 16,
    parameter int POINTS_Z    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [2:0]  i_energy_index,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [14:0] i_load_address,
    input  logic [31:0] i_load_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_flux_value,
    output logic        o_outside,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int XW = $clog2(POINTS_X);
    localparam int YW = $clog2(POINTS_Y);
    localparam int ZW = $clog2(POINTS_Z);

    localparam logic [XW-1:0] X_MAX = XW'(POINTS_X - 1);
    localparam logic [YW-1:0] Y_MAX = YW'(POINTS_Y - 1);
    localparam logic [ZW-1:0] Z_MAX = ZW'(POINTS_Z - 1);
    localparam t_pos NM1_X = POS_W'(POINTS_X - 1);
    localparam t_pos NM1_Y = POS_W'(POINTS_Y - 1);
    localparam t_pos NM1_Z = POS_W'(POINTS_Z - 1);

    localparam t_addr PX_A  = t_addr'(POINTS_X);
    localparam t_addr PY_A  = t_addr'(POINTS_Y);
    localparam t_addr PZ_A  = t_addr'(POINTS_Z);
    localparam t_addr OFF_Z = t_addr'(1);
    localparam t_addr OFF_Y = t_addr'(POINTS_Z);
    localparam t_addr OFF_X = t_addr'((POINTS_Y * POINTS_Z) % (2 ** ADDR_W));

    localparam logic [2:0] E_MAX = 3'((ENERGY_BINS > 8) ? 7 : ENERGY_BINS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAP, ST_ADDR, ST_READ, ST_EDGE, ST_ZWAIT,
        ST_YL0, ST_YL1, ST_YWAIT, ST_XL, ST_XWAIT, ST_OUT
    } t_state;

    typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} t_axis;

    t_state r_state, n_state;
    logic [1:0] r_mc;
    logic [2:0] r_k;
    logic [2:0] r_lcnt;
    logic       r_out_valid;
    t_flux      r_out_flux;
    logic       r_out_outside;

    t_pos r_x_lower, r_y_lower, r_z_lower;
    t_pos r_x_scale, r_y_scale, r_z_scale;

    t_pos       r_pos_x, r_pos_y, r_pos_z;
    logic [2:0] r_energy;

    logic              r_d_vld;
    t_axis             r_d_ax;
    logic [POS_W:0]    r_d;
    logic              r_p_vld;
    t_axis             r_p_ax;
    logic [2*POS_W-1:0] r_prod;
    logic              r_pout;

    logic [XW-1:0] r_idx_x;
    logic [YW-1:0] r_idx_y;
    logic [ZW-1:0] r_idx_z;
    t_frac         r_frac_x, r_frac_y, r_frac_z;
    logic          r_outside;
    logic          r_edge;
    t_addr         r_base;

    logic  r_rd_vld;
    logic  r_rd_odd;
    t_flux r_even;
    t_flux r_zq [0:3];
    t_flux r_w  [0:1];
    t_flux r_res;

    logic  in_accept;
    logic  out_free;
    logic  out_load;
    logic  mem_we;
    t_addr mem_addr;
    t_addr rd_addr;
    t_flux mem_rdata;

    t_axis sub_ax;
    t_pos  sub_pos, sub_lower;
    t_pos  mul_scale, mul_d;
    t_pos  chk_nm1;
    logic  chk_out;
    t_addr t1, t2, base_calc;
    logic  edge_calc;
    logic [2:0] e_sat;

    logic  lerp_in_vld;
    t_flux lerp_a, lerp_b;
    t_frac lerp_f;
    logic  lerp_out_vld;
    t_flux lerp_res;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == ST_OUT) && out_free;

    assign o_out_valid  = r_out_valid;
    assign o_flux_value = r_out_flux;
    assign o_outside    = r_out_outside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lower <= '0;
            r_y_lower <= '0;
            r_z_lower <= '0;
            r_x_scale <= 32'h0001_0000;
            r_y_scale <= 32'h0001_0000;
            r_z_scale <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_X_LOWER: r_x_lower <= i_cfg_data;
                REG_Y_LOWER: r_y_lower <= i_cfg_data;
                REG_Z_LOWER: r_z_lower <= i_cfg_data;
                REG_X_SCALE: r_x_scale <= i_cfg_data;
                REG_Y_SCALE: r_y_scale <= i_cfg_data;
                REG_Z_SCALE: r_z_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        e_sat = i_energy_index;
        if (int'(i_energy_index) >= ENERGY_BINS) begin
            e_sat = E_MAX;
        end
    end

    always_comb begin
        sub_ax    = t_axis'(r_mc);
        sub_pos   = '0;
        sub_lower = '0;
        case (sub_ax)
            AX_X: begin
                sub_pos   = r_pos_x;
                sub_lower = r_x_lower;
            end
            AX_Y: begin
                sub_pos   = r_pos_y;
                sub_lower = r_y_lower;
            end
            AX_Z: begin
                sub_pos   = r_pos_z;
                sub_lower = r_z_lower;
            end
            default: ;
        endcase
    end

    always_comb begin
        case (r_d_ax)
            AX_X:    mul_scale = r_x_scale;
            AX_Y:    mul_scale = r_y_scale;
            AX_Z:    mul_scale = r_z_scale;
            default: mul_scale = '0;
        endcase
        mul_d = r_d[POS_W] ? '0 : r_d[POS_W-1:0];
    end

    always_comb begin
        case (r_p_ax)
            AX_X:    chk_nm1 = NM1_X;
            AX_Y:    chk_nm1 = NM1_Y;
            AX_Z:    chk_nm1 = NM1_Z;
            default: chk_nm1 = '0;
        endcase
        chk_out = r_pout
               || (r_prod[2*POS_W-1:POS_W] > chk_nm1)
               || ((r_prod[2*POS_W-1:POS_W] == chk_nm1) && (r_prod[POS_W-1:0] != '0));
    end

    always_comb begin
        t1        = t_addr'(r_energy) * PX_A + t_addr'(r_idx_x);
        t2        = t1 * PY_A + t_addr'(r_idx_y);
        base_calc = t2 * PZ_A + t_addr'(r_idx_z);
        edge_calc = (r_idx_x == X_MAX) || (r_idx_y == Y_MAX) || (r_idx_z == Z_MAX);
    end

    always_comb begin
        rd_addr = r_base + (r_k[0] ? OFF_Z : '0) + (r_k[1] ? OFF_Y : '0)
                + (r_k[2] ? OFF_X : '0);
        mem_we   = in_accept && (i_mode == MODE_LOAD);
        mem_addr = (r_state == ST_IDLE) ? i_load_address : rd_addr;
    end

    always_comb begin
        lerp_in_vld = 1'b0;
        lerp_a      = r_even;
        lerp_b      = mem_rdata;
        lerp_f      = r_frac_z;
        if (r_rd_vld && r_rd_odd) begin
            lerp_in_vld = 1'b1;
        end
        case (r_state)
            ST_YL0: begin
                lerp_in_vld = 1'b1;
                lerp_a      = r_zq[3];
                lerp_b      = r_zq[2];
                lerp_f      = r_frac_y;
            end
            ST_YL1: begin
                lerp_in_vld = 1'b1;
                lerp_a      = r_zq[1];
                lerp_b      = r_zq[0];
                lerp_f      = r_frac_y;
            end
            ST_XL: begin
                lerp_in_vld = 1'b1;
                lerp_a      = r_w[1];
                lerp_b      = r_w[0];
                lerp_f      = r_frac_x;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_mode != MODE_LOAD)) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                if (r_p_vld && (r_p_ax == AX_Z)) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR:  n_state = r_outside ? ST_OUT : ST_READ;
            ST_READ: begin
                if (r_edge) begin
                    n_state = ST_EDGE;
                end else if (r_k == 3'd7) begin
                    n_state = ST_ZWAIT;
                end
            end
            ST_EDGE:  n_state = ST_OUT;
            ST_ZWAIT: n_state = (r_lcnt == 3'd4) ? ST_YL0 : ST_ZWAIT;
            ST_YL0:   n_state = ST_YL1;
            ST_YL1:   n_state = ST_YWAIT;
            ST_YWAIT: n_state = (r_lcnt == 3'd6) ? ST_XL : ST_YWAIT;
            ST_XL:    n_state = ST_XWAIT;
            ST_XWAIT: n_state = (r_lcnt == 3'd7) ? ST_OUT : ST_XWAIT;
            ST_OUT:   n_state = out_free ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_mc          <= '0;
            r_k           <= '0;
            r_lcnt        <= '0;
            r_d_vld       <= 1'b0;
            r_p_vld       <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_flux    <= '0;
            r_out_outside <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_d_vld  <= (r_state == ST_MAP) && (r_mc != 2'd3);
            r_p_vld  <= r_d_vld;
            r_rd_vld <= (r_state == ST_READ) && !r_edge;
            if (r_state == ST_IDLE) begin
                r_mc   <= '0;
                r_k    <= '0;
                r_lcnt <= '0;
            end
            if ((r_state == ST_MAP) && (r_mc != 2'd3)) begin
                r_mc <= r_mc + 2'd1;
            end
            if (r_state == ST_READ) begin
                r_k <= r_k + 3'd1;
            end
            if (lerp_out_vld) begin
                r_lcnt <= r_lcnt + 3'd1;
            end
            if (out_load) begin
                r_out_valid   <= 1'b1;
                r_out_flux    <= r_res;
                r_out_outside <= r_outside;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pos_x   <= i_pos_x;
            r_pos_y   <= i_pos_y;
            r_pos_z   <= i_pos_z;
            r_energy  <= e_sat;
            r_outside <= 1'b0;
        end
        r_d_ax <= sub_ax;
        r_d    <= {sub_pos[POS_W-1], sub_pos} - {sub_lower[POS_W-1], sub_lower};
        r_p_ax <= r_d_ax;
        r_prod <= mul_scale * mul_d;
        r_pout <= r_d[POS_W] && (mul_scale != '0);
        if (r_p_vld) begin
            if (chk_out) begin
                r_outside <= 1'b1;
            end
            case (r_p_ax)
                AX_X: begin
                    r_idx_x  <= r_prod[POS_W +: XW];
                    r_frac_x <= r_prod[POS_W-1:FRAC_W];
                end
                AX_Y: begin
                    r_idx_y  <= r_prod[POS_W +: YW];
                    r_frac_y <= r_prod[POS_W-1:FRAC_W];
                end
                AX_Z: begin
                    r_idx_z  <= r_prod[POS_W +: ZW];
                    r_frac_z <= r_prod[POS_W-1:FRAC_W];
                end
                default: ;
            endcase
        end
        if (r_state == ST_ADDR) begin
            r_base <= base_calc;
            r_edge <= edge_calc;
            r_res  <= '0;
        end
        r_rd_odd <= r_k[0];
        if (r_rd_vld && !r_rd_odd) begin
            r_even <= mem_rdata;
        end
        if (r_state == ST_EDGE) begin
            r_res <= mem_rdata;
        end
        if (lerp_out_vld) begin
            if (r_lcnt < 3'd4) begin
                r_zq[0] <= lerp_res;
                r_zq[1] <= r_zq[0];
                r_zq[2] <= r_zq[1];
                r_zq[3] <= r_zq[2];
            end else if (r_lcnt < 3'd6) begin
                r_w[0] <= lerp_res;
                r_w[1] <= r_w[0];
            end else begin
                r_res <= lerp_res;
            end
        end
    end

    tgi_flux_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_load_value),
        .o_rdata (mem_rdata)
    );

    tgi_lerp u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (lerp_in_vld),
        .i_a      (lerp_a),
        .i_b      (lerp_b),
        .i_frac   (lerp_f),
        .o_valid  (lerp_out_vld),
        .o_result (lerp_res)
    );

`ifndef NO_ASSERTIONS
    a_lerp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lerp_out_vld |-> (r_lcnt != 3'd7))
        else $error("interpolation unit returned more than seven words");

    a_lerp_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lerp_out_vld |-> (r_state == ST_READ || r_state == ST_ZWAIT
                          || r_state == ST_YWAIT || r_state == ST_XWAIT))
        else $error("interpolation word arrived outside a collecting state");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_outside || r_edge || r_lcnt == 3'd7))
        else $error("result word loaded before interpolation finished");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outside) |-> (o_flux_value == '0))
        else $error("outside result carries non-zero flux");
`endif

endmodule
